FILE: sv/ackp_pkg.sv
// Shared types, codes and helper functions for the ACK frame range parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ackp_pkg;

  // Result kind codes
  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Done record status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // Type byte: bit that flags the block count and gap/length blocks
  localparam int unsigned TYPE_BLOCKS_BIT = 5;

  // Field widths
  localparam int unsigned PN_W    = 64;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned DELAY_W = 42;
  localparam int unsigned RCNT_W  = 9;

  // Result slots in the output buffer
  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);

  // One result item
  typedef struct packed {
    logic               item_kind;
    logic [PN_W-1:0]    range_high;
    logic [PN_W-1:0]    range_low;
    logic               status;
    logic [POS_W-1:0]   consumed_bytes;
    logic [DELAY_W-1:0] ack_delay_us;
    logic [RCNT_W-1:0]  range_total;
    logic [7:0]         timestamp_total;
    logic               run_last;
  } res_t;

  // Up to two results written by one parsed byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

  // Map a two-bit size code to a field length of 1, 2, 4 or 6 bytes
  function automatic logic [2:0] size_of(input logic [1:0] code);
    logic [2:0] len;
    case (code)
      2'd0:    len = 3'd1;
      2'd1:    len = 3'd2;
      2'd2:    len = 3'd4;
      default: len = 3'd6;
    endcase
    return len;
  endfunction

  // Decode the 16-bit float ack delay: 5-bit exponent over an 11-bit
  // mantissa with a hidden bit once the exponent is nonzero.
  function automatic logic [DELAY_W-1:0] float16_decode(input logic [15:0] v);
    logic [4:0]         ex;
    logic [DELAY_W-1:0] mant;
    logic [DELAY_W-1:0] res;
    ex   = v[15:11] & 5'h1F;
    mant = {{(DELAY_W-12){1'b0}}, 1'b1, v[10:0]};
    if (ex == 5'd0) begin
      res = {{(DELAY_W-16){1'b0}}, v};
    end else begin
      res = mant << (ex - 5'd1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ackp_in_stage.sv
// Input register of the ACK frame range parser: holds one byte transfer
// until the parse core takes it. Depends on ackp_pkg only for house style.
`default_nettype none

module ackp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] frame_byte,
  input  wire logic       buffer_end,
  input  wire logic       take,
  output logic            hold_valid,
  output logic [7:0]      hold_byte,
  output logic            hold_end
);
  import ackp_pkg::*;

  logic accept;

  // Stall only while a held byte cannot move on this cycle
  assign in_stall = hold_valid & ~take;
  assign accept   = in_valid & ~in_stall;

  // Valid flag: load on transfer, drop when the core takes the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload: capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= frame_byte;
      hold_end  <= buffer_end;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ackp_parse_core.sv
// Byte-at-a-time parse state of the ACK frame and the result records each
// byte produces. Depends on ackp_pkg for types, codes and decode helpers.
`default_nettype none

module ackp_parse_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          frame_byte,
  input  wire logic                buffer_end,
  output ackp_pkg::res_pair_t      wr
);
  import ackp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LARGE, PH_DELAY, PH_NBLK, PH_FIRST,
    PH_GAP, PH_BLEN, PH_TSC, PH_SKIP, PH_TAIL
  } phase_t;

  // Parse state
  phase_t             phase,        phase_next;
  logic [7:0]         type_bits,    type_bits_next;
  logic [POS_W-1:0]   pos,          pos_next;
  logic [ACC_W-1:0]   acc,          acc_next;
  logic [2:0]         left,         left_next;
  logic [7:0]         blocks,       blocks_next;
  logic [15:0]        gap_sum,      gap_sum_next;
  logic [PN_W-1:0]    low_mark,     low_mark_next;
  logic [PN_W-1:0]    gap_high,     gap_high_next;
  logic [RCNT_W-1:0]  ranges,       ranges_next;
  logic [7:0]         ts_count,     ts_count_next;
  logic [9:0]         skip_left,    skip_left_next;
  logic [DELAY_W-1:0] delay,        delay_next;

  // Step helpers
  logic [ACC_W-1:0]   acc_shift;
  logic [PN_W-1:0]    acc_wide;
  logic [2:0]         left_dec;
  logic               field_done;
  logic [2:0]         blen;
  logic [15:0]        gap_new;
  logic [7:0]         blocks_dec;
  logic [9:0]         skip_dec;
  logic [9:0]         tsc_m1;
  logic [PN_W-1:0]    range_hi;
  logic [PN_W-1:0]    range_lo;
  logic               emit_range;
  logic               finished;
  logic               emit_done;
  logic               done_status;
  res_t               range_res;
  res_t               done_res;

  assign acc_shift  = {acc[ACC_W-9:0], frame_byte};
  assign acc_wide   = {{(PN_W-ACC_W){1'b0}}, acc_shift};
  assign left_dec   = (left != 3'd0) ? left - 3'd1 : 3'd0;
  assign field_done = (left_dec == 3'd0);
  assign blen       = size_of(type_bits[1:0]);
  assign gap_new    = gap_sum + {8'd0, frame_byte};
  assign blocks_dec = (blocks != 8'd0) ? blocks - 8'd1 : 8'd0;
  assign skip_dec   = (skip_left != 10'd0) ? skip_left - 10'd1 : 10'd0;
  assign tsc_m1     = {2'd0, frame_byte} - 10'd1;

  // Advance the parse by one byte
  always_comb begin
    phase_next     = phase;
    type_bits_next = type_bits;
    pos_next       = pos;
    acc_next       = acc;
    left_next      = left;
    blocks_next    = blocks;
    gap_sum_next   = gap_sum;
    low_mark_next  = low_mark;
    gap_high_next  = gap_high;
    ranges_next    = ranges;
    ts_count_next  = ts_count;
    skip_left_next = skip_left;
    delay_next     = delay;
    range_hi       = '0;
    range_lo       = '0;
    emit_range     = 1'b0;
    finished       = 1'b0;

    if (phase != PH_IDLE && phase != PH_TAIL) begin
      pos_next = pos + POS_W'(1);
    end

    case (phase)
      PH_IDLE: begin
        type_bits_next = frame_byte;
        pos_next       = POS_W'(1);
        delay_next     = '0;
        ranges_next    = '0;
        ts_count_next  = '0;
        gap_sum_next   = '0;
        blocks_next    = '0;
        low_mark_next  = '0;
        skip_left_next = '0;
        acc_next       = '0;
        left_next      = size_of(frame_byte[3:2]);
        phase_next     = PH_LARGE;
      end
      PH_LARGE: begin
        acc_next  = acc_shift;
        left_next = left_dec;
        if (field_done) begin
          low_mark_next = acc_wide;
          acc_next      = '0;
          left_next     = 3'd2;
          phase_next    = PH_DELAY;
        end
      end
      PH_DELAY: begin
        acc_next  = acc_shift;
        left_next = left_dec;
        if (field_done) begin
          delay_next = float16_decode(acc_shift[15:0]);
          acc_next   = '0;
          left_next  = blen;
          if (type_bits[TYPE_BLOCKS_BIT]) begin
            phase_next = PH_NBLK;
          end else begin
            phase_next = PH_FIRST;
          end
        end
      end
      PH_NBLK: begin
        blocks_next = frame_byte;
        acc_next    = '0;
        left_next   = blen;
        phase_next  = PH_FIRST;
      end
      PH_FIRST: begin
        acc_next  = acc_shift;
        left_next = left_dec;
        if (field_done) begin
          range_hi      = low_mark;
          range_lo      = low_mark - acc_wide + PN_W'(1);
          emit_range    = 1'b1;
          low_mark_next = range_lo;
          ranges_next   = RCNT_W'(1);
          phase_next    = (blocks != 8'd0) ? PH_GAP : PH_TSC;
        end
      end
      PH_GAP: begin
        // Gaps add up across zero-length blocks; precompute the next high end
        gap_sum_next  = gap_new;
        gap_high_next = low_mark + ~{{(PN_W-16){1'b0}}, gap_new};
        acc_next      = '0;
        left_next     = blen;
        phase_next    = PH_BLEN;
      end
      PH_BLEN: begin
        acc_next  = acc_shift;
        left_next = left_dec;
        if (field_done) begin
          if (acc_shift != '0) begin
            range_hi      = gap_high;
            range_lo      = gap_high - acc_wide + PN_W'(1);
            emit_range    = 1'b1;
            low_mark_next = range_lo;
            ranges_next   = ranges + RCNT_W'(1);
            gap_sum_next  = '0;
          end
          blocks_next = blocks_dec;
          phase_next  = (blocks_dec != 8'd0) ? PH_GAP : PH_TSC;
        end
      end
      PH_TSC: begin
        ts_count_next = frame_byte;
        if (frame_byte == 8'd0) begin
          finished = 1'b1;
        end else begin
          skip_left_next = 10'd5 + {tsc_m1[8:0], 1'b0} + tsc_m1;
          phase_next     = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 10'd0) begin
          finished = 1'b1;
        end
      end
      PH_TAIL: begin
        phase_next = PH_TAIL;
      end
      default: begin
        phase_next = PH_TAIL;
      end
    endcase

    // Close the frame: normal end, or buffer ran out mid-frame
    emit_done   = 1'b0;
    done_status = STATUS_OK;
    if (finished) begin
      emit_done  = 1'b1;
      phase_next = buffer_end ? PH_IDLE : PH_TAIL;
    end else if (buffer_end) begin
      if (phase_next != PH_TAIL) begin
        emit_done   = 1'b1;
        done_status = STATUS_SHORT;
      end
      phase_next = PH_IDLE;
    end
  end

  // Build the result records
  always_comb begin
    range_res            = '0;
    range_res.item_kind  = KIND_RANGE;
    range_res.range_high = range_hi;
    range_res.range_low  = range_lo;
    range_res.run_last   = ~emit_done;

    done_res                 = '0;
    done_res.item_kind       = KIND_DONE;
    done_res.status          = done_status;
    done_res.consumed_bytes  = pos_next;
    done_res.ack_delay_us    = delay_next;
    done_res.range_total     = ranges_next;
    done_res.timestamp_total = ts_count_next;
    done_res.run_last        = 1'b1;

    wr.res1 = done_res;
    if (emit_range) begin
      wr.res0 = range_res;
      wr.cnt  = emit_done ? 2'd2 : 2'd1;
    end else begin
      wr.res0 = done_res;
      wr.cnt  = emit_done ? 2'd1 : 2'd0;
    end
    if (!step) begin
      wr.cnt = 2'd0;
    end
  end

  // Hold parse state; advance on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      type_bits <= '0;
      pos       <= '0;
      acc       <= '0;
      left      <= '0;
      blocks    <= '0;
      gap_sum   <= '0;
      low_mark  <= '0;
      gap_high  <= '0;
      ranges    <= '0;
      ts_count  <= '0;
      skip_left <= '0;
      delay     <= '0;
    end else if (step) begin
      phase     <= phase_next;
      type_bits <= type_bits_next;
      pos       <= pos_next;
      acc       <= acc_next;
      left      <= left_next;
      blocks    <= blocks_next;
      gap_sum   <= gap_sum_next;
      low_mark  <= low_mark_next;
      gap_high  <= gap_high_next;
      ranges    <= ranges_next;
      ts_count  <= ts_count_next;
      skip_left <= skip_left_next;
      delay     <= delay_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ackp_res_buf.sv
// Result buffer of the ACK frame range parser: takes up to two records a
// cycle from the parse core and presents one per output transfer.
// Depends on ackp_pkg for the record types and depth.
`default_nettype none

module ackp_res_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ackp_pkg::res_pair_t wr,
  output logic                     room2,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ackp_pkg::res_t           head
);
  import ackp_pkg::*;

  res_t              mem [BUF_DEPTH];
  logic [BUF_AW-1:0] wr_ptr;
  logic [BUF_AW-1:0] rd_ptr;
  logic [BUF_AW:0]   count;
  logic              rd;

  assign out_valid = (count != '0);
  assign rd        = out_valid & ~out_stall;
  assign room2     = (count <= (BUF_AW+1)'(BUF_DEPTH - 2));
  assign head      = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + BUF_AW'(wr.cnt);
      if (rd) begin
        rd_ptr <= rd_ptr + BUF_AW'(1);
      end
      count <= count + (BUF_AW+1)'(wr.cnt) - (BUF_AW+1)'(rd);
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem[wr_ptr] <= wr.res0;
    end
    if (wr.cnt == 2'd2) begin
      mem[wr_ptr + BUF_AW'(1)] <= wr.res1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ack_frame_range_parser.sv
// ACK frame range parser, top level: input register, parse core and
// result buffer. Depends on ackp_pkg, ackp_in_stage, ackp_parse_core and
// ackp_res_buf.
//
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per transfer, with
//   buffer_end set on the last byte of the buffer. The first byte of a
//   frame is the type byte.
//   Output channel (out_valid / out_stall): range records (item_kind 0)
//   as the first range and each nonzero block length complete, then one
//   done record (item_kind 1) per frame with status, consumed_bytes,
//   ack_delay_us, range_total and timestamp_total. run_last marks the last
//   record caused by a byte. A record passes the input register and the
//   result buffer, both registered; the byte waits while the buffer lacks room.
//   Throughput: one byte per cycle while the buffer has room for two
//   records; a range and a done record from one byte leave one at a time
//   through the single read port of the four-entry result buffer.
//   Reset: the parser returns to waiting for a type byte and the input
//   register and result buffer are emptied.
//   Stall: records wait in the result buffer; once fewer than two slots
//   are free the held input byte waits and in_stall rises.
`default_nettype none

module ack_frame_range_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             item_kind,
  output logic [63:0]      range_high,
  output logic [63:0]      range_low,
  output logic             status,
  output logic [11:0]      consumed_bytes,
  output logic [41:0]      ack_delay_us,
  output logic [8:0]       range_total,
  output logic [7:0]       timestamp_total,
  output logic             run_last
);
  import ackp_pkg::*;

  logic      hold_valid;
  logic [7:0] hold_byte;
  logic      hold_end;
  logic      take;
  logic      room2;
  res_pair_t wr;
  res_t      head;

  // Move the held byte into the core when the buffer has room for two records
  assign take = hold_valid & room2;

  ackp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .frame_byte (frame_byte),
    .buffer_end (buffer_end),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .hold_end   (hold_end)
  );

  ackp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (take),
    .frame_byte (hold_byte),
    .buffer_end (hold_end),
    .wr         (wr)
  );

  ackp_res_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Unpack the head record onto the output ports
  assign item_kind       = head.item_kind;
  assign range_high      = head.range_high;
  assign range_low       = head.range_low;
  assign status          = head.status;
  assign consumed_bytes  = head.consumed_bytes;
  assign ack_delay_us    = head.ack_delay_us;
  assign range_total     = head.range_total;
  assign timestamp_total = head.timestamp_total;
  assign run_last        = head.run_last;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for ack_frame_range_parser: directed table, then random ACK frames.
// Depends on ackp_pkg and the ack_frame_range_parser RTL; carries its own frame predictor.
`timescale 1ns / 100ps

module tb;
  import ackp_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_REPORTS  = 100;

  typedef enum logic [3:0] {
    P_IDLE, P_LARGEST, P_DELAY, P_COUNT, P_FIRST, P_GAP, P_LEN, P_STAMPS, P_SKIP, P_TAIL
  } parse_phase_t;

  // One byte to send; typed rows carry the done record read straight off the frame
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic        want_status;
    logic [11:0] want_bytes;
    logic [41:0] want_delay;
    logic [8:0]  want_ranges;
    logic [7:0]  want_stamps;
  } feed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  frame_byte = 8'h00;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        item_kind;
  logic [63:0] range_high;
  logic [63:0] range_low;
  logic        status;
  logic [11:0] consumed_bytes;
  logic [41:0] ack_delay_us;
  logic [8:0]  range_total;
  logic [7:0]  timestamp_total;
  logic        run_last;

  feed_row_t directed_rows [23];
  feed_row_t feed_q [$];
  logic [7:0] draft_frame [$];
  res_t      byte_records [$];
  res_t      awaited_records [$];
  int        frame_items = 0;
  int        mismatches = 0;
  bit        feed_done = 1'b0;

  // Predictor state
  parse_phase_t p_phase = P_IDLE;
  logic [7:0]   p_type = '0;
  logic [11:0]  p_pos = '0;
  logic [63:0]  p_acc = '0;
  logic [2:0]   p_acc_left = '0;
  logic [7:0]   p_blocks = '0;
  logic [15:0]  p_gaps = '0;
  logic [63:0]  p_low_mark = '0;
  logic [8:0]   p_ranges = '0;
  logic [7:0]   p_stamps = '0;
  logic [9:0]   p_skip = '0;
  logic [41:0]  p_delay = '0;

  always #1 clk = ~clk;

  ack_frame_range_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .frame_byte(frame_byte), .buffer_end(buffer_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .item_kind(item_kind), .range_high(range_high), .range_low(range_low),
    .status(status), .consumed_bytes(consumed_bytes), .ack_delay_us(ack_delay_us),
    .range_total(range_total), .timestamp_total(timestamp_total), .run_last(run_last)
  );

  // Two-bit size code to field length in bytes
  function automatic int field_bytes(input logic [1:0] code);
    int n;
    case (code)
      2'd0:    n = 1;
      2'd1:    n = 2;
      2'd2:    n = 4;
      default: n = 6;
    endcase
    return n;
  endfunction

  // 16-bit float: 5-bit exponent, 11-bit mantissa, hidden bit when exponent is nonzero
  function automatic logic [41:0] delay_from_float(input logic [15:0] f);
    logic [41:0] us;
    if (f[15:11] == 5'd0) begin
      us = 42'(f);
    end else begin
      us = 42'({1'b1, f[10:0]}) << (f[15:11] - 5'd1);
    end
    return us;
  endfunction

  function automatic res_t range_record(input logic [63:0] hi, input logic [63:0] lo);
    res_t rec;
    rec = '0;
    rec.item_kind  = KIND_RANGE;
    rec.range_high = hi;
    rec.range_low  = lo;
    return rec;
  endfunction

  function automatic res_t done_record(input logic st, input logic [11:0] n_bytes,
                                       input logic [41:0] dly, input logic [8:0] rng_count,
                                       input logic [7:0] n_stamps);
    res_t rec;
    rec = '0;
    rec.item_kind       = KIND_DONE;
    rec.status          = st;
    rec.consumed_bytes  = n_bytes;
    rec.ack_delay_us    = dly;
    rec.range_total     = rng_count;
    rec.timestamp_total = n_stamps;
    return rec;
  endfunction

  function automatic void open_field(input int n);
    p_acc      = '0;
    p_acc_left = 3'(n);
  endfunction

  // Shift one byte into the field; true once the field is complete
  function automatic bit shift_in(input logic [7:0] b);
    p_acc = {p_acc[55:0], b};
    if (p_acc_left != 3'd0) p_acc_left = p_acc_left - 3'd1;
    return p_acc_left == 3'd0;
  endfunction

  // Advance the frame parse by one byte; records it causes land in byte_records
  task automatic parse_frame_byte(input logic [7:0] b, input logic fin);
    logic        finished;
    int          len_bytes;
    logic [63:0] hi;
    logic [63:0] lo;
    res_t        rec;
    finished  = 1'b0;
    len_bytes = field_bytes(p_type[1:0]);
    byte_records.delete();
    if (p_phase != P_IDLE && p_phase != P_TAIL) p_pos = p_pos + 12'd1;
    case (p_phase)
      P_IDLE: begin
        p_type     = b;
        p_pos      = 12'd1;
        p_delay    = '0;
        p_ranges   = '0;
        p_stamps   = '0;
        p_gaps     = '0;
        p_blocks   = '0;
        p_low_mark = '0;
        p_skip     = '0;
        open_field(field_bytes(b[3:2]));
        p_phase = P_LARGEST;
      end
      P_LARGEST: begin
        if (shift_in(b)) begin
          p_low_mark = p_acc;
          open_field(2);
          p_phase = P_DELAY;
        end
      end
      P_DELAY: begin
        if (shift_in(b)) begin
          p_delay = delay_from_float(p_acc[15:0]);
          if (p_type[TYPE_BLOCKS_BIT]) begin
            p_phase = P_COUNT;
          end else begin
            open_field(len_bytes);
            p_phase = P_FIRST;
          end
        end
      end
      P_COUNT: begin
        p_blocks = b;
        open_field(len_bytes);
        p_phase = P_FIRST;
      end
      P_FIRST: begin
        if (shift_in(b)) begin
          hi = p_low_mark;
          lo = hi - p_acc + 64'd1;
          byte_records.push_back(range_record(hi, lo));
          p_low_mark = lo;
          p_ranges   = 9'd1;
          p_phase    = (p_blocks != 8'd0) ? P_GAP : P_STAMPS;
        end
      end
      P_GAP: begin
        p_gaps = p_gaps + 16'(b);
        open_field(len_bytes);
        p_phase = P_LEN;
      end
      P_LEN: begin
        if (shift_in(b)) begin
          // zero-length block: no range, gap carries into the next one
          if (p_acc != 64'd0) begin
            hi = p_low_mark - 64'(p_gaps) - 64'd1;
            lo = hi - p_acc + 64'd1;
            byte_records.push_back(range_record(hi, lo));
            p_low_mark = lo;
            p_ranges   = p_ranges + 9'd1;
            p_gaps     = '0;
          end
          if (p_blocks != 8'd0) p_blocks = p_blocks - 8'd1;
          p_phase = (p_blocks != 8'd0) ? P_GAP : P_STAMPS;
        end
      end
      P_STAMPS: begin
        p_stamps = b;
        if (b == 8'd0) begin
          finished = 1'b1;
        end else begin
          p_skip  = 10'(5 + 3 * (int'(b) - 1));
          p_phase = P_SKIP;
        end
      end
      P_SKIP: begin
        if (p_skip != 10'd0) p_skip = p_skip - 10'd1;
        if (p_skip == 10'd0) finished = 1'b1;
      end
      default: p_phase = P_TAIL;
    endcase

    if (finished) begin
      byte_records.push_back(done_record(STATUS_OK, p_pos, p_delay, p_ranges, p_stamps));
      p_phase = fin ? P_IDLE : P_TAIL;
    end else if (fin) begin
      if (p_phase != P_TAIL)
        byte_records.push_back(done_record(STATUS_SHORT, p_pos, p_delay, p_ranges, p_stamps));
      p_phase = P_IDLE;
    end

    // Mark the last record of this byte
    if (byte_records.size() != 0) begin
      rec = byte_records.pop_back();
      rec.run_last = 1'b1;
      byte_records.push_back(rec);
    end
  endtask

  // Idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_byte(input logic [7:0] data, input logic last);
    feed_q.push_back('{data, last, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0});
  endtask

  // Block length field: often zero, sometimes small, otherwise random
  task automatic draft_length(input int n);
    int r;
    r = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if (r < 3 || (r < 5 && i != n - 1)) draft_frame.push_back(8'h00);
      else draft_frame.push_back(8'($urandom));
    end
  endtask

  // Well-formed frame with random content; some truncated, some with trailing bytes.
  // Very long frames are drawn only while the item budget still has room for them.
  task automatic build_random_frame();
    logic [7:0] kind;
    int         blocks;
    int         stamps;
    int         cut;
    int         r;
    int         room;
    room = RANDOM_ITEMS - frame_items;
    draft_frame.delete();
    kind = 8'($urandom);
    draft_frame.push_back(kind);
    repeat (field_bytes(kind[3:2])) draft_frame.push_back(8'($urandom));
    repeat (2) draft_frame.push_back(8'($urandom));
    blocks = 0;
    if (kind[TYPE_BLOCKS_BIT]) begin
      r = $urandom_range(0, 99);
      if (r < 70) blocks = $urandom_range(0, 4);
      else if (r < 98) blocks = $urandom_range(5, 40);
      else if (room > 255 * (field_bytes(kind[1:0]) + 1) + 64)
        blocks = $urandom_range(200, 255);
      else blocks = $urandom_range(5, 40);
      draft_frame.push_back(8'(blocks));
    end
    draft_length(field_bytes(kind[1:0]));
    repeat (blocks) begin
      draft_frame.push_back(8'($urandom));
      draft_length(field_bytes(kind[1:0]));
    end
    r = $urandom_range(0, 99);
    if (r < 60) stamps = 0;
    else if (r < 96) stamps = $urandom_range(1, 3);
    else if (r < 99 || room <= 900) stamps = $urandom_range(4, 20);
    else stamps = $urandom_range(21, 255);
    draft_frame.push_back(8'(stamps));
    if (stamps != 0) repeat (5 + 3 * (stamps - 1)) draft_frame.push_back(8'($urandom));

    r = $urandom_range(0, 99);
    if (r < 15) begin
      cut = $urandom_range(1, draft_frame.size());
      for (int i = 0; i < cut; i++) queue_byte(draft_frame[i], i == cut - 1);
      frame_items += cut;
    end else if (r < 55) begin
      for (int i = 0; i < draft_frame.size(); i++)
        queue_byte(draft_frame[i], i == draft_frame.size() - 1);
      frame_items += draft_frame.size();
    end else begin
      foreach (draft_frame[i]) queue_byte(draft_frame[i], 1'b0);
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
      queue_byte(8'($urandom), 1'b1);
      frame_items += draft_frame.size();
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Stimulus setup, reset and end of run
  initial begin : main
    int n;
    // type byte alone, flagged: short buffer right after reset
    directed_rows[0]  = '{8'hFF, 1'b1, 1'b1, STATUS_SHORT, 12'd1, 42'd0, 9'd0, 8'd0};
    // blocks present, 6-byte largest of zero, max float delay, wrapping first range,
    // zero-length block whose gap carries, then trailing bytes that are dropped
    directed_rows[1]  = '{8'h2C, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    for (int i = 2; i < 8; i++)
      directed_rows[i] = '{8'h00, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[8]  = '{8'hFF, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[9]  = '{8'hFF, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[10] = '{8'h02, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[11] = '{8'h02, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[12] = '{8'h05, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[13] = '{8'h00, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[14] = '{8'hFF, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[15] = '{8'h01, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[16] = '{8'h00, 1'b0, 1'b1, STATUS_OK, 12'd16, 42'h3FF_C000_0000, 9'd2,
                          8'd0};
    directed_rows[17] = '{8'hA5, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[18] = '{8'h5A, 1'b1, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    // buffer runs out right after the delay field
    directed_rows[19] = '{8'h03, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[20] = '{8'h05, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[21] = '{8'h00, 1'b0, 1'b0, STATUS_OK, 12'd0, 42'd0, 9'd0, 8'd0};
    directed_rows[22] = '{8'h00, 1'b1, 1'b1, STATUS_SHORT, 12'd4, 42'd0, 9'd0, 8'd0};
    foreach (directed_rows[k]) feed_q.push_back(directed_rows[k]);

    // Random part: mostly frames, some raw noise
    while (frame_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          queue_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
        frame_items += n;
      end else begin
        build_random_frame();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (!feed_done) @(posedge clk);
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_records.size() == 0) begin
      $display("ack_frame_range_parser regression: pass");
    end else begin
      $display("ack_frame_range_parser regression: fail");
    end
    $finish;
  end

  // Sender: offer bytes with random gaps; predict at each accepted transfer
  initial begin : sender
    int idx;
    int gap_left;
    int calm;
    res_t rec;
    idx = 0;
    gap_left = 0;
    calm = 0;
    while (rst) @(posedge clk);
    while (idx < feed_q.size() || in_valid) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        parse_frame_byte(feed_q[idx].data, feed_q[idx].last);
        if (feed_q[idx].typed && byte_records.size() != 0) begin
          rec = done_record(feed_q[idx].want_status, feed_q[idx].want_bytes,
                            feed_q[idx].want_delay, feed_q[idx].want_ranges,
                            feed_q[idx].want_stamps);
          rec.run_last = 1'b1;
          byte_records[byte_records.size() - 1] = rec;
        end
        while (byte_records.size() != 0) awaited_records.push_back(byte_records.pop_front());
        idx++;
        gap_left = pick_idle(calm);
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (idx < feed_q.size() && gap_left == 0) begin
        in_valid   <= 1'b1;
        frame_byte <= feed_q[idx].data;
        buffer_end <= feed_q[idx].last;
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
    feed_done = 1'b1;
  end

  // Receiver: check each record transfer, stall at random, hold off long now and then
  initial begin : receiver
    int   hold_left;
    int   stall_left;
    int   calm;
    int   seen;
    int   next_hold;
    res_t want;
    hold_left = 0;
    stall_left = 0;
    calm = 0;
    seen = 0;
    next_hold = 40;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        seen++;
        if (awaited_records.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: record with nothing expected, kind %0d", $time, item_kind);
        end else begin
          want = awaited_records.pop_front();
          compare_field("item_kind", 64'(want.item_kind), 64'(item_kind));
          compare_field("range_high", want.range_high, range_high);
          compare_field("range_low", want.range_low, range_low);
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("consumed_bytes", 64'(want.consumed_bytes), 64'(consumed_bytes));
          compare_field("ack_delay_us", 64'(want.ack_delay_us), 64'(ack_delay_us));
          compare_field("range_total", 64'(want.range_total), 64'(range_total));
          compare_field("timestamp_total", 64'(want.timestamp_total), 64'(timestamp_total));
          compare_field("run_last", 64'(want.run_last), 64'(run_last));
        end
      end
      if (hold_left == 0 && seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle(calm);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("ack_frame_range_parser regression: fail");
    $finish;
  end

endmodule
